@@ rtl/fpfa_pkg.sv @@
// ---------------------------------------------------------------------------
// fpfa_pkg
// shared types and constants for the fixed partition fit allocator
// ---------------------------------------------------------------------------
`default_nettype none

package fpfa_pkg;

    localparam int NUM_PARTITIONS = 16;
    localparam int SIZE_BITS      = 24;
    localparam int IDX_BITS       = $clog2(NUM_PARTITIONS);
    localparam int CNT_BITS       = $clog2(NUM_PARTITIONS + 1);
    localparam int PID_BITS       = 16;
    localparam int ADDR_BITS      = 28;
    localparam int OP_BITS        = 2;
    localparam int STATUS_BITS    = 3;
    localparam int MODE_BITS      = 2;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 5;

    localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FREE  = 2'd2;

    localparam logic [MODE_BITS-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_BITS-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_BITS-1:0] FIT_WORST = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_ZERO     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOFIT    = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_DUP      = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_MODE   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PART_COUNT = 1'd1;

    localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(NUM_PARTITIONS);

    typedef struct packed {
        logic [OP_BITS-1:0]   opcode;
        logic [IDX_BITS-1:0]  part_index;
        logic [SIZE_BITS-1:0] amount;
        logic [PID_BITS-1:0]  process_id;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [IDX_BITS-1:0]    chosen_block;
        logic [ADDR_BITS-1:0]   base_address;
        logic [ADDR_BITS-1:0]   limit_address;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/fixed_partition_fit_allocator_top.sv @@
// ---------------------------------------------------------------------------
// fixed_partition_fit_allocator_top
// steps: load goes straight to output; free: owner scan, base sum, output;
// allocate: owner scan over 16 partitions, fit scan of partition_count,
// base sum up to the chosen index, output; one size read port serves fit scan
// and base sum, one adder the sum; one item at a time, none taken until emitted
// reset: synchronous active low; sizes read zero, all partitions free,
// fit_mode first fit, partition_count 16; owner ids are not cleared
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_partition_fit_allocator_top
    import fpfa_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire t_in_item                 i_in_item,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output t_out_item                     o_out_item,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OWN_SCAN,
        S_FIT_SCAN,
        S_SUM,
        S_EMIT
    } t_state;

    t_state                      r_state, n_state;
    logic [MODE_BITS-1:0]        r_mode, n_mode;
    logic [CNT_BITS-1:0]         r_count, n_count;
    logic [NUM_PARTITIONS-1:0]   r_busy, n_busy;
    logic [NUM_PARTITIONS-1:0]   r_size_vld, n_size_vld;
    logic [OP_BITS-1:0]          r_op, n_op;
    logic [SIZE_BITS-1:0]        r_amt, n_amt;
    logic [PID_BITS-1:0]         r_pid, n_pid;
    logic [IDX_BITS-1:0]         r_idx, n_idx;
    logic [IDX_BITS-1:0]         r_pick, n_pick;
    logic [SIZE_BITS-1:0]        r_pick_sz, n_pick_sz;
    logic                        r_found, n_found;
    logic [ADDR_BITS-1:0]        r_base, n_base;
    t_out_item                   r_res, n_res;
    t_out_item                   r_out, n_out;
    logic                        r_out_vld, n_out_vld;

    logic [SIZE_BITS-1:0]        r_size  [NUM_PARTITIONS];
    logic [PID_BITS-1:0]         r_owner [NUM_PARTITIONS];

    logic                        size_we;
    logic [IDX_BITS-1:0]         size_wa;
    logic                        own_we;
    logic [IDX_BITS-1:0]         own_wa;

    logic [SIZE_BITS-1:0]        rd_sz;
    logic [CNT_BITS-1:0]         count_eff;
    logic                        idx_last_all;
    logic                        idx_last_fit;
    logic                        own_hit;
    logic                        cand;
    logic                        better;
    logic                        fit_done;
    logic [ADDR_BITS-1:0]        sum;
    logic                        accept;

    assign rd_sz        = r_size_vld[r_idx] ? r_size[r_idx] : '0;
    assign count_eff    = (r_count > COUNT_RESET) ? COUNT_RESET : r_count;
    assign idx_last_all = (r_idx == IDX_BITS'(NUM_PARTITIONS - 1));
    assign idx_last_fit = ({1'b0, r_idx} == (count_eff - CNT_BITS'(1)));
    assign own_hit      = r_busy[r_idx] && (r_owner[r_idx] == r_pid);
    assign cand         = !r_busy[r_idx] && (rd_sz >= r_amt);
    assign better       = !r_found
                          || ((r_mode == FIT_BEST) && (rd_sz < r_pick_sz))
                          || ((r_mode == FIT_WORST) && (rd_sz > r_pick_sz));
    assign fit_done     = (cand && (r_mode == FIT_FIRST)) || idx_last_fit;
    assign sum          = r_base + ADDR_BITS'(rd_sz);
    assign accept       = i_in_valid && !o_in_stall;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_out_item   = r_out;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_count    = r_count;
        n_busy     = r_busy;
        n_size_vld = r_size_vld;
        n_op       = r_op;
        n_amt      = r_amt;
        n_pid      = r_pid;
        n_idx      = r_idx;
        n_pick     = r_pick;
        n_pick_sz  = r_pick_sz;
        n_found    = r_found;
        n_base     = r_base;
        n_res      = r_res;
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        size_we    = 1'b0;
        size_wa    = i_in_item.part_index;
        own_we     = 1'b0;
        own_wa     = r_pick;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIT_MODE:   n_mode  = i_cfg_data[MODE_BITS-1:0];
                CFG_PART_COUNT: n_count = i_cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = i_in_item.opcode;
                    n_amt = i_in_item.amount;
                    n_pid = i_in_item.process_id;
                    n_idx = '0;
                    n_res = '0;
                    case (i_in_item.opcode)
                        OP_LOAD: begin
                            size_we = 1'b1;
                            n_size_vld[i_in_item.part_index] = 1'b1;
                            n_res.chosen_block = i_in_item.part_index;
                            n_state = S_EMIT;
                        end
                        OP_ALLOC: begin
                            if (i_in_item.amount == '0) begin
                                n_res.status = ST_ZERO;
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_OWN_SCAN;
                            end
                        end
                        OP_FREE: begin
                            n_state = S_OWN_SCAN;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_OWN_SCAN: begin
                if (own_hit) begin
                    if (r_op == OP_FREE) begin
                        n_busy[r_idx] = 1'b0;
                        n_pick  = r_idx;
                        n_idx   = '0;
                        n_base  = '0;
                        n_state = S_SUM;
                    end else begin
                        n_res.status = ST_DUP;
                        n_state = S_EMIT;
                    end
                end else if (idx_last_all) begin
                    if (r_op == OP_FREE) begin
                        n_res.status = ST_NOTFOUND;
                        n_state = S_EMIT;
                    end else if ((r_mode > FIT_WORST) || (count_eff == '0)) begin
                        n_res.status = ST_NOFIT;
                        n_state = S_EMIT;
                    end else begin
                        n_idx   = '0;
                        n_found = 1'b0;
                        n_state = S_FIT_SCAN;
                    end
                end else begin
                    n_idx = r_idx + IDX_BITS'(1);
                end
            end
            S_FIT_SCAN: begin
                if (cand && better) begin
                    n_found   = 1'b1;
                    n_pick    = r_idx;
                    n_pick_sz = rd_sz;
                end
                if (fit_done) begin
                    if (!n_found) begin
                        n_res.status = ST_NOFIT;
                        n_state = S_EMIT;
                    end else begin
                        n_busy[n_pick] = 1'b1;
                        own_we  = 1'b1;
                        own_wa  = n_pick;
                        n_idx   = '0;
                        n_base  = '0;
                        n_state = S_SUM;
                    end
                end else begin
                    n_idx = r_idx + IDX_BITS'(1);
                end
            end
            S_SUM: begin
                if (r_idx == r_pick) begin
                    n_res.status        = ST_OK;
                    n_res.chosen_block  = r_pick;
                    n_res.base_address  = r_base;
                    n_res.limit_address = sum;
                    n_state = S_EMIT;
                end else begin
                    n_base = sum;
                    n_idx  = r_idx + IDX_BITS'(1);
                end
            end
            S_EMIT: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= FIT_FIRST;
            r_count    <= COUNT_RESET;
            r_busy     <= '0;
            r_size_vld <= '0;
            r_found    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_count    <= n_count;
            r_busy     <= n_busy;
            r_size_vld <= n_size_vld;
            r_found    <= n_found;
            r_out_vld  <= n_out_vld;
        end
        r_op      <= n_op;
        r_amt     <= n_amt;
        r_pid     <= n_pid;
        r_idx     <= n_idx;
        r_pick    <= n_pick;
        r_pick_sz <= n_pick_sz;
        r_base    <= n_base;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    // partition size and owner tables
    always_ff @(posedge i_clk) begin
        if (size_we) begin
            r_size[size_wa] <= i_in_item.amount;
        end
        if (own_we) begin
            r_owner[own_wa] <= r_pid;
        end
    end

    a_err_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status != ST_OK)) |->
        (r_out.chosen_block == '0) && (r_out.base_address == '0)
        && (r_out.limit_address == '0))
        else $error("error item carries nonzero fields");

    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_EMIT))
        else $error("result item raised outside emit");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_idx <= r_pick))
        else $error("base sum ran past chosen partition");

    a_fit_mode_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIT_SCAN) |-> (r_mode <= FIT_WORST))
        else $error("fit scan with invalid mode");

    a_alloc_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SUM) && (r_op == OP_ALLOC)) |-> r_busy[r_pick])
        else $error("allocated partition not busy");

endmodule

`default_nettype wire
